>>> hdl/dmxpfa_pkg.sv
// Shared types, codes and sizes for the DMX universe to pixel frame assembler.
package dmxpfa_pkg;

  localparam int CMD_W        = 2;
  localparam int UNIVERSE_W   = 15;
  localparam int CHANNEL_W    = 9;
  localparam int BYTE_W       = 8;
  localparam int PIXEL_IDX_W  = 11;
  localparam int COMPONENT_W  = 2;
  localparam int RESETS_W     = 16;
  localparam int PIXEL_CNT_W  = 12;
  localparam int UCOUNT_W     = 7;
  // universe * 512 + channel for up to 64 universes
  localparam int POS_W        = 15;
  // quotient of a position by three
  localparam int PIX_W        = 14;

  localparam int DEF_MAX_PIXELS    = 2048;
  localparam int DEF_MAX_UNIVERSES = 16;
  localparam int DEF_QUEUE_DEPTH   = 4;

  localparam logic [PIXEL_CNT_W-1:0] PIXEL_COUNT_RESET = 12'd2048;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FRAME = 1'b1
  } kind_t;

  // front to back work item
  typedef struct packed {
    kind_t               kind;
    logic [POS_W-1:0]    pos;
    logic [BYTE_W-1:0]   value;
    logic [RESETS_W-1:0] resets;
  } work_t;

endpackage

>>> hdl/dmxpfa_in_if.sv
// Input channel: DMX command items with valid/ready handshake.
interface dmxpfa_in_if
  import dmxpfa_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [UNIVERSE_W-1:0] universe;
  logic [CHANNEL_W-1:0]  channel;
  logic [BYTE_W-1:0]     channel_value;

  modport source (output valid, command, universe, channel, channel_value, input ready);
  modport sink   (input valid, command, universe, channel, channel_value, output ready);
endinterface

>>> hdl/dmxpfa_out_if.sv
// Output channel: pixel component writes and frame completion items.
interface dmxpfa_out_if
  import dmxpfa_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [PIXEL_IDX_W-1:0] pixel_index;
  logic [COMPONENT_W-1:0] component;
  logic [BYTE_W-1:0]      pixel_value;
  logic [RESETS_W-1:0]    resets_seen;

  modport source (output valid, kind, pixel_index, component, pixel_value, resets_seen,
                  input ready);
  modport sink   (input valid, kind, pixel_index, component, pixel_value, resets_seen,
                  output ready);
endinterface

>>> hdl/dmxpfa_front.sv
// Front end: takes command items, tracks frame state, emits work items.
module dmxpfa_front
  import dmxpfa_pkg::*;
#(
  parameter int MAX_PIXELS    = DEF_MAX_PIXELS,
  parameter int MAX_UNIVERSES = DEF_MAX_UNIVERSES
) (
  input  logic                   clk,
  input  logic                   rst,
  dmxpfa_in_if.sink              din,
  input  logic                   cfg_we,
  input  logic [PIXEL_CNT_W-1:0] cfg_data,
  input  logic                   q_full,
  output logic                   push,
  output work_t                  push_item,
  output logic [PIXEL_CNT_W-1:0] eff_pixels
);

  localparam int UW = (MAX_UNIVERSES > 1) ? $clog2(MAX_UNIVERSES) : 1;
  localparam int CW = $clog2(MAX_UNIVERSES + 1);

  logic [PIXEL_CNT_W-1:0]   pixel_count;
  logic [MAX_UNIVERSES-1:0] received_mask, received_mask_next;
  logic [CW-1:0]            received_count, received_count_next;
  logic [UW-1:0]            current_universe, current_universe_next;
  logic                     accepting, accepting_next;
  logic [RESETS_W-1:0]      reset_counter, reset_counter_next;

  logic [PIXEL_CNT_W-1:0]   eff;
  logic [13:0]              triple;
  logic [14:0]              rounded;
  logic [UCOUNT_W-1:0]      ucount;
  logic [MAX_UNIVERSES-1:0] uni_bit;
  logic                     in_range;
  logic                     accept;
  logic                     complete;

  assign accept   = din.valid && din.ready;
  assign din.ready = !q_full;

  always_comb begin
    eff = (pixel_count == '0) ? PIXEL_CNT_W'(1) : pixel_count;
    if (14'(eff) > 14'(MAX_PIXELS)) begin
      eff = PIXEL_CNT_W'(MAX_PIXELS);
    end
    triple  = {1'b0, eff, 1'b0} + {2'b00, eff};
    rounded = {1'b0, triple} + 15'd511;
    ucount  = {1'b0, rounded[14:9]};
    if (ucount > UCOUNT_W'(MAX_UNIVERSES)) begin
      ucount = UCOUNT_W'(MAX_UNIVERSES);
    end
  end

  assign eff_pixels = eff;
  assign in_range   = din.universe < UNIVERSE_W'(ucount);
  assign complete   = UCOUNT_W'(received_count) == ucount;

  always_comb begin
    for (int i = 0; i < MAX_UNIVERSES; i++) begin
      uni_bit[i] = din.universe == UNIVERSE_W'(i);
    end
  end

  always_comb begin
    received_mask_next    = received_mask;
    received_count_next   = received_count;
    current_universe_next = current_universe;
    accepting_next        = accepting;
    reset_counter_next    = reset_counter;
    push                  = 1'b0;
    push_item.kind        = KIND_PIXEL;
    push_item.pos         = POS_W'({current_universe, din.channel});
    push_item.value       = din.channel_value;
    push_item.resets      = reset_counter;
    if (cfg_we) begin
      received_mask_next  = '0;
      received_count_next = '0;
      accepting_next      = 1'b0;
    end else if (accept) begin
      case (cmd_t'(din.command))
        CMD_BEGIN: begin
          if (!in_range) begin
            accepting_next = 1'b0;
          end else begin
            if (din.universe == '0 && received_count != '0 && !complete) begin
              received_mask_next  = '0;
              received_count_next = '0;
              if (reset_counter != '1) begin
                reset_counter_next = reset_counter + 1'b1;
              end
            end
            if ((received_mask_next & uni_bit) != '0) begin
              // duplicate universe
              received_mask_next  = '0;
              received_count_next = '0;
              accepting_next      = 1'b0;
              if (reset_counter_next != '1) begin
                reset_counter_next = reset_counter_next + 1'b1;
              end
            end else begin
              received_mask_next    = received_mask_next | uni_bit;
              received_count_next   = received_count_next + 1'b1;
              current_universe_next = din.universe[UW-1:0];
              accepting_next        = 1'b1;
            end
          end
        end
        CMD_BYTE: begin
          push = accepting;
        end
        CMD_END: begin
          if (accepting) begin
            accepting_next = 1'b0;
            if (complete) begin
              push                = 1'b1;
              push_item.kind      = KIND_FRAME;
              received_mask_next  = '0;
              received_count_next = '0;
              reset_counter_next  = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count      <= PIXEL_COUNT_RESET;
      received_mask    <= '0;
      received_count   <= '0;
      current_universe <= '0;
      accepting        <= 1'b0;
      reset_counter    <= '0;
    end else begin
      if (cfg_we) begin
        pixel_count <= cfg_data;
      end
      received_mask    <= received_mask_next;
      received_count   <= received_count_next;
      current_universe <= current_universe_next;
      accepting        <= accepting_next;
      reset_counter    <= reset_counter_next;
    end
  end

endmodule

>>> hdl/dmxpfa_queue.sv
// Short FIFO of work items between front and back.
module dmxpfa_queue
  import dmxpfa_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_item,
  input  logic  pop,
  output work_t head,
  output logic  full,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  work_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_push, do_pop;

  assign full    = count == (AW + 1)'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/dmxpfa_back.sv
// Back end: maps positions to pixel and component, drops overflow, drives output register.
module dmxpfa_back
  import dmxpfa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  work_t                  head,
  input  logic                   empty,
  input  logic [PIXEL_CNT_W-1:0] eff_pixels,
  output logic                   pop,
  dmxpfa_out_if.source           dout
);

  logic [31:0]            product;
  logic [PIX_W-1:0]       pix;
  logic [POS_W-1:0]       triple;
  logic [POS_W-1:0]       rem;
  logic                   drop;
  logic                   can_load;

  // divide by three: exact reciprocal for positions below 2^16
  assign product = 32'(head.pos) * 32'd43691;
  assign pix     = product[17 +: PIX_W];
  assign triple  = POS_W'({pix, 1'b0}) + POS_W'(pix);
  assign rem     = head.pos - triple;
  assign drop    = head.kind == KIND_PIXEL && pix >= PIX_W'(eff_pixels);

  assign can_load = !dout.valid || dout.ready;
  assign pop      = !empty && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (can_load) begin
      dout.valid <= pop && !drop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dout.kind <= head.kind;
      if (head.kind == KIND_FRAME) begin
        dout.pixel_index <= '0;
        dout.component   <= '0;
        dout.pixel_value <= '0;
        dout.resets_seen <= head.resets;
      end else begin
        dout.pixel_index <= pix[PIXEL_IDX_W-1:0];
        dout.component   <= rem[COMPONENT_W-1:0];
        dout.pixel_value <= head.value;
        dout.resets_seen <= '0;
      end
    end
  end

endmodule

>>> hdl/dmx_universe_pixel_frame_assembler.sv
// Top level of the DMX universe to RGB pixel frame assembler.
//
//   channel  dir  payload                                              handshake
//   din      in   command, universe, channel, channel_value             valid/ready
//   dout     out  kind, pixel_index, component, pixel_value, resets_seen valid/ready
//   cfg      in   cfg_data (pixel_count)                                cfg_we
//
// One item per cycle sustained while dout is ready; a byte reaches dout through the
// queue (written at the accepting edge), then divide-by-three into the output register.
// Frame state lives in the front; the back is a single multiply stage by a reciprocal.
// din.ready drops only when the work queue is full, i.e. dout stalled for several items.
// rst is synchronous; no clearing pass, the block takes items the cycle after reset.
module dmx_universe_pixel_frame_assembler
  import dmxpfa_pkg::*;
#(
  parameter int MAX_PIXELS    = DEF_MAX_PIXELS,
  parameter int MAX_UNIVERSES = DEF_MAX_UNIVERSES
) (
  input  logic                   clk,
  input  logic                   rst,
  dmxpfa_in_if.sink              din,
  dmxpfa_out_if.source           dout,
  input  logic                   cfg_we,
  input  logic [PIXEL_CNT_W-1:0] cfg_data
);

  logic                   push, pop, q_full, q_empty;
  work_t                  push_item, head;
  logic [PIXEL_CNT_W-1:0] eff_pixels;

  dmxpfa_front #(
    .MAX_PIXELS    (MAX_PIXELS),
    .MAX_UNIVERSES (MAX_UNIVERSES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item),
    .eff_pixels (eff_pixels)
  );

  dmxpfa_queue #(
    .DEPTH (DEF_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  dmxpfa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .eff_pixels (eff_pixels),
    .pop        (pop),
    .dout       (dout)
  );

endmodule
